// ===== sv/gfp_pkg.sv =====
// Package with the constants, codes and shared types of the gyro frame parser.
package gfp_pkg;

    localparam int unsigned FRAME_BYTES = 22;
    localparam int unsigned POS_W       = 5;

    localparam logic [7:0] SUM_SEED = 8'h55;
    localparam logic [7:0] YAW_TYPE = 8'h53;

    // Byte positions inside a frame.
    localparam logic [POS_W-1:0] POS_SUM1_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SUM1_LAST  = POS_W'(9);
    localparam logic [POS_W-1:0] POS_CHECK1     = POS_W'(10);
    localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(12);
    localparam logic [POS_W-1:0] POS_SUM2_FIRST = POS_W'(12);
    localparam logic [POS_W-1:0] POS_SUM2_LAST  = POS_W'(20);
    localparam logic [POS_W-1:0] POS_WORD1_LO   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_WORD1_HI   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_WORD2_LO   = POS_W'(17);
    localparam logic [POS_W-1:0] POS_WORD2_HI   = POS_W'(18);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_CHECKSUM = 2'd1,
        STAT_LENGTH   = 2'd2
    } t_status;

    // What the parser reports for the byte now in the working stage.
    typedef struct packed {
        logic        done;
        t_status     status;
        logic [15:0] raw;
    } t_frame_info;

endpackage

// ===== sv/gfp_frame_parse.sv =====
// Frame parser: byte position, packet sums and the captured fields of a frame.
module gfp_frame_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_end,
    output gfp_pkg::t_frame_info o_info
);
    import gfp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum1, n_sum1;
    logic [7:0]       r_sum2, n_sum2;
    logic [7:0]       r_check1, n_check1;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_word1, n_word1;
    logic [15:0]      r_word2, n_word2;
    logic             full;
    logic             ok;

    always_comb begin
        n_sum1   = r_sum1;
        n_sum2   = r_sum2;
        n_check1 = r_check1;
        n_type   = r_type;
        n_word1  = r_word1;
        n_word2  = r_word2;
        if (r_pos >= POS_SUM1_FIRST && r_pos <= POS_SUM1_LAST) n_sum1 = r_sum1 + i_rx_byte;
        if (r_pos >= POS_SUM2_FIRST && r_pos <= POS_SUM2_LAST) n_sum2 = r_sum2 + i_rx_byte;
        if (r_pos == POS_CHECK1)   n_check1      = i_rx_byte;
        if (r_pos == POS_TYPE)     n_type        = i_rx_byte;
        if (r_pos == POS_WORD1_LO) n_word1[7:0]  = i_rx_byte;
        if (r_pos == POS_WORD1_HI) n_word1[15:8] = i_rx_byte;
        if (r_pos == POS_WORD2_LO) n_word2[7:0]  = i_rx_byte;
        if (r_pos == POS_WORD2_HI) n_word2[15:8] = i_rx_byte;

        // The last byte is the second packet's check byte; it adds to no sum.
        full = (r_pos >= POS_LAST);
        ok   = full && (n_sum1 == n_check1) && (n_sum2 == i_rx_byte);

        o_info.done = full || i_frame_end;
        if (!full) begin
            o_info.status = STAT_LENGTH;
            o_info.raw    = '0;
        end else if (!ok) begin
            o_info.status = STAT_CHECKSUM;
            o_info.raw    = '0;
        end else begin
            o_info.status = STAT_OK;
            o_info.raw    = (n_type == YAW_TYPE) ? n_word2 : n_word1;
        end

        if (o_info.done) begin
            n_pos  = '0;
            n_sum1 = SUM_SEED;
            n_sum2 = SUM_SEED;
        end else begin
            n_pos  = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum1   <= SUM_SEED;
            r_sum2   <= SUM_SEED;
            r_check1 <= '0;
            r_type   <= '0;
            r_word1  <= '0;
            r_word2  <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_sum1   <= n_sum1;
            r_sum2   <= n_sum2;
            r_check1 <= n_check1;
            r_type   <= n_type;
            r_word1  <= n_word1;
            r_word2  <= n_word2;
        end
    end

endmodule

// ===== sv/gfp_unwrap.sv =====
// Angle unwrapper: keeps the last raw angle and the running 32-bit heading.
module gfp_unwrap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  gfp_pkg::t_frame_info i_info,
    output logic [31:0]          o_heading,
    output logic [31:0]          o_cumulative
);
    import gfp_pkg::*;

    logic [15:0]        r_prev;
    logic [31:0]        r_cum, n_cum;
    logic signed [16:0] diff;
    logic signed [17:0] delta;
    logic               accept;

    always_comb begin
        accept = i_info.done && (i_info.status == STAT_OK);
        diff   = 17'(signed'(i_info.raw)) - 17'(signed'(r_prev));
        // Differences past half a turn wrap by a full turn; exactly half is kept.
        if (diff > 17'sd32768) begin
            delta = 18'(diff) - 18'sd65536;
        end else if (diff < -17'sd32768) begin
            delta = 18'(diff) + 18'sd65536;
        end else begin
            delta = 18'(diff);
        end
        n_cum     = r_cum + 32'(delta);
        o_heading = accept ? n_cum : r_cum;
    end

    assign o_cumulative = r_cum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cum  <= '0;
        end else if (i_fire && accept) begin
            r_prev <= i_info.raw;
            r_cum  <= n_cum;
        end
    end

endmodule

// ===== sv/gyro_frame_parse_angle_unwrap.sv =====
// Top level of the gyro frame parser with checksum test and angle unwrapping.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+--------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_rx_byte, i_frame_end
//  output  | o_out_valid  | i_out_ready  | o_heading, o_raw_angle, o_status
//
// Every byte is registered in an input stage and processed there by short logic. A byte
// that ends a frame writes the result register once that register has room, and the
// result register then offers the result. A byte can be taken in every cycle unless the
// input stalls. The only wait comes from the result register: a frame end cannot leave
// the input stage while an untaken result is held, and then the input stalls too. Reset
// is synchronous and active low; it restarts frame and heading.
module gyro_frame_parse_angle_unwrap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_heading,
    output logic signed [15:0] o_raw_angle,
    output logic [1:0]  o_status
);
    import gfp_pkg::*;

    // Input stage.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    // Result register.
    logic        r_out_valid;
    logic [31:0] r_heading;
    logic [15:0] r_raw;
    t_status     r_status;

    t_frame_info info;
    logic [31:0] heading_next;
    logic [31:0] cumulative;
    logic        out_free;
    logic        stage_fire;

    // The stage moves on when its byte ends no frame or the result register has room.
    assign out_free   = !r_out_valid || i_out_ready;
    assign stage_fire = r_in_valid && (!info.done || out_free);
    assign o_in_ready = !r_in_valid || stage_fire;

    gfp_frame_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (stage_fire),
        .i_rx_byte   (r_in_byte),
        .i_frame_end (r_in_end),
        .o_info      (info)
    );

    gfp_unwrap u_unwrap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (stage_fire),
        .i_info       (info),
        .o_heading    (heading_next),
        .o_cumulative (cumulative)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && info.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && info.done) begin
            r_heading <= heading_next;
            r_raw     <= info.raw;
            r_status  <= info.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_heading   = signed'(r_heading);
    assign o_raw_angle = signed'(r_raw);
    assign o_status    = r_status;

    // A rejected frame carries no angle.
    a_reject_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STAT_OK) |-> (r_raw == 16'd0))
        else $error("rejected frame carries a nonzero raw angle");

    // A rejected frame reports the running heading, which it leaves untouched.
    a_reject_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_fire && info.done && info.status != STAT_OK)
        |=> (r_heading == cumulative) && $stable(cumulative))
        else $error("rejected frame changed or misreported the heading");

    // A byte that ends no frame never holds up the input stage.
    a_no_stall_midframe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !info.done) |-> o_in_ready)
        else $error("input stalled on a byte that ends no frame");

    // A held result is never overwritten.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(stage_fire && info.done))
        else $error("result register overwritten before it was taken");

endmodule
